@@ hdl/hrf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_pkg
// Types, constants and the arctangent table shared by the haversine filter.
// ----------------------------------------------------------------------------
package hrf_pkg;

  typedef logic [15:0]        tag_t;
  typedef logic signed [23:0] lat_t;
  typedef logic signed [24:0] lon_t;
  typedef logic [22:0]        dist_t;
  typedef logic [25:0]        mag_t;
  typedef logic signed [32:0] trig_t;

  typedef enum logic [1:0] {
    CFG_QUERY_LAT = 2'd0,
    CFG_QUERY_LON = 2'd1,
    CFG_RADIUS    = 2'd2
  } cfg_reg_t;

  localparam int CFG_DATA_W = 25;

  // floor(x / 45) == (x * DIV45_MUL) >> DIV45_SHIFT for x <= 2^25
  localparam logic [28:0] DIV45_MUL   = 29'd381774871;
  localparam int          DIV45_SHIFT = 34;

  localparam trig_t       CORDIC_GAIN  = 33'sd652032874;
  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
  localparam logic [30:0] DIST_SCALE   = 31'd1311708728;
  localparam dist_t       DIST_MAX     = 23'd5123862;
  localparam dist_t       RADIUS_RESET = 23'd25600;
  localparam int          SQRT_STEPS   = 31;
  localparam int          SQ_W         = 62;

  // atan(2^-i) as a binary angle, 2^32 per turn
  function automatic logic [29:0] atan_bam(input int idx);
    unique case (idx)
      0:  atan_bam = 30'd536870912;
      1:  atan_bam = 30'd316933406;
      2:  atan_bam = 30'd167458907;
      3:  atan_bam = 30'd85004756;
      4:  atan_bam = 30'd42667331;
      5:  atan_bam = 30'd21354465;
      6:  atan_bam = 30'd10679838;
      7:  atan_bam = 30'd5340245;
      8:  atan_bam = 30'd2670163;
      9:  atan_bam = 30'd1335087;
      10: atan_bam = 30'd667544;
      11: atan_bam = 30'd333772;
      12: atan_bam = 30'd166886;
      13: atan_bam = 30'd83443;
      14: atan_bam = 30'd41722;
      15: atan_bam = 30'd20861;
      16: atan_bam = 30'd10430;
      17: atan_bam = 30'd5215;
      18: atan_bam = 30'd2608;
      19: atan_bam = 30'd1304;
      20: atan_bam = 30'd652;
      21: atan_bam = 30'd326;
      22: atan_bam = 30'd163;
      23: atan_bam = 30'd81;
      24: atan_bam = 30'd41;
      25: atan_bam = 30'd20;
      26: atan_bam = 30'd10;
      27: atan_bam = 30'd5;
      28: atan_bam = 30'd3;
      29: atan_bam = 30'd1;
      30: atan_bam = 30'd1;
      default: atan_bam = 30'd0;
    endcase
  endfunction

endpackage

@@ hdl/hrf_point_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_point_if
// Candidate point channel: valid/ready and the point payload.
// ----------------------------------------------------------------------------
interface hrf_point_if import hrf_pkg::*; ();
  logic valid;
  logic ready;
  tag_t point_tag;
  lat_t point_latitude;
  lon_t point_longitude;

  modport source  (output valid, point_tag, point_latitude, point_longitude, input ready);
  modport sink    (input valid, point_tag, point_latitude, point_longitude, output ready);
  modport monitor (input valid, ready, point_tag, point_latitude, point_longitude);
endinterface

@@ hdl/hrf_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_result_if
// Result channel: valid/ready, tag, distance and the radius flag.
// ----------------------------------------------------------------------------
interface hrf_result_if import hrf_pkg::*; ();
  logic  valid;
  logic  ready;
  tag_t  result_tag;
  dist_t distance;
  logic  within_radius;

  modport source  (output valid, result_tag, distance, within_radius, input ready);
  modport sink    (input valid, result_tag, distance, within_radius, output ready);
  modport monitor (input valid, ready, result_tag, distance, within_radius);
endinterface

@@ hdl/haversine_radius_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_radius_filter_top
// Haversine great-circle distance from a configured query point, with an
// inclusive radius flag.
//
//   channel   dir   payload
//   point     in    point_tag, point_latitude, point_longitude
//   result    out   result_tag, distance, within_radius
//   cfg       in    cfg_we, cfg_index, cfg_data (write only)
//
// One request per cycle while the result is not stalled. The pipe sections,
// in order: angle conversion, sine/cosine CORDIC, products, square roots,
// atan2 CORDIC and scaling. Reset clears the valid pipe and the query point,
// and sets the radius to RADIUS_RESET. A stalled result freezes the whole
// pipe; point.ready falls in the same cycle.
// ----------------------------------------------------------------------------
module haversine_radius_filter_top import hrf_pkg::*; #(
  parameter int CORDIC_STEPS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  hrf_point_if.sink             point,
  hrf_result_if.source          result
);

  localparam int LAT = 2 * CORDIC_STEPS + 45;

  function automatic mag_t f_mag(input logic signed [25:0] v);
    f_mag = v[25] ? mag_t'(-v) : mag_t'(v);
  endfunction

  lat_t  query_latitude;
  lon_t  query_longitude;
  dist_t radius_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_latitude  <= '0;
      query_longitude <= '0;
      radius_limit    <= RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUERY_LAT: query_latitude  <= cfg_data[23:0];
        CFG_QUERY_LON: query_longitude <= cfg_data[24:0];
        CFG_RADIUS:    radius_limit    <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  // pipe control
  logic       advance;
  logic       vld [0:LAT-1];
  tag_t       tg  [0:LAT-1];

  assign advance     = !vld[LAT-1] || result.ready;
  assign point.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vld[k] <= 1'b0;
    end else if (advance) begin
      vld[0] <= point.valid;
      for (int k = 1; k < LAT; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tg[0] <= point.point_tag;
      for (int k = 1; k < LAT; k++) tg[k] <= tg[k-1];
    end
  end

  // lanes: half dlat, half dlon, query latitude, point latitude
  logic signed [24:0] dlat_w;
  logic signed [25:0] dlon_w;
  mag_t               lat1_mag_w;
  mag_t               lat2_mag_w;
  mag_t               lane_mag [4];
  logic               lane_neg [4];
  trig_t              sc_sin   [4];
  trig_t              sc_cos   [4];

  assign dlat_w     = 25'(point.point_latitude) - 25'(query_latitude);
  assign dlon_w     = 26'(point.point_longitude) - 26'(query_longitude);
  assign lat1_mag_w = f_mag(26'(query_latitude));
  assign lat2_mag_w = f_mag(26'(point.point_latitude));

  assign lane_mag[0] = f_mag(26'(dlat_w));
  assign lane_neg[0] = dlat_w[24];
  assign lane_mag[1] = f_mag(dlon_w);
  assign lane_neg[1] = dlon_w[25];
  assign lane_mag[2] = {lat1_mag_w[24:0], 1'b0};
  assign lane_neg[2] = query_latitude[23];
  assign lane_mag[3] = {lat2_mag_w[24:0], 1'b0};
  assign lane_neg[3] = point.point_latitude[23];

  // binary angle = round(mag * 4096 / 45) = {mag / 45, (4096 * rem + 22) / 45}
  for (genvar j = 0; j < 4; j++) begin : g_lane
    mag_t        s1_mag;
    logic        s1_neg;
    logic [19:0] s2_quo;
    mag_t        s2_mag;
    logic        s2_neg;
    logic [19:0] s3_quo;
    logic [5:0]  s3_rem;
    logic        s3_neg;
    logic [19:0] s4_quo;
    logic [11:0] s4_frac;
    logic        s4_neg;
    logic [31:0] s5_bam;
    logic [54:0] quo_prod;
    mag_t        rem_full;
    logic [17:0] frac_num;
    logic [46:0] frac_prod;
    logic [31:0] q_w;

    assign quo_prod  = s1_mag * DIV45_MUL;
    assign rem_full  = s2_mag - 26'(s2_quo) * 26'd45;
    assign frac_num  = {s3_rem, 12'b0} + 18'd22;
    assign frac_prod = frac_num * DIV45_MUL;
    assign q_w       = {s4_quo, s4_frac};

    always_ff @(posedge clk) begin
      if (advance) begin
        s1_mag  <= lane_mag[j];
        s1_neg  <= lane_neg[j];
        s2_quo  <= quo_prod[DIV45_SHIFT+19:DIV45_SHIFT];
        s2_mag  <= s1_mag;
        s2_neg  <= s1_neg;
        s3_quo  <= s2_quo;
        s3_rem  <= rem_full[5:0];
        s3_neg  <= s2_neg;
        s4_quo  <= s3_quo;
        s4_frac <= frac_prod[DIV45_SHIFT+11:DIV45_SHIFT];
        s4_neg  <= s3_neg;
        s5_bam  <= s4_neg ? 32'(-q_w) : q_w;
      end
    end

    hrf_sincos #(.STEPS(CORDIC_STEPS)) u_sincos (
      .clk     (clk),
      .en      (advance),
      .ang     (s5_bam),
      .sin_q30 (sc_sin[j]),
      .cos_q30 (sc_cos[j])
    );
  end

  // haversine term
  logic signed [65:0] sq1_w, sq2_w, pr3_w, pr4_w;
  logic signed [33:0] sum_w;
  logic [30:0]        hav_w;
  trig_t m1_p1, m1_p2, m1_c1, m1_c2;
  trig_t m2_p1, m2_p3, m2_c2;
  trig_t m3_p1, m3_p4;

  assign sq1_w = sc_sin[0] * sc_sin[0];
  assign sq2_w = sc_sin[1] * sc_sin[1];
  assign pr3_w = m1_p2 * m1_c1;
  assign pr4_w = m2_p3 * m2_c2;
  assign sum_w = 34'(m3_p1) + 34'(m3_p4);

  always_comb begin
    priority if (sum_w < 34'sd0) begin
      hav_w = '0;
    end else if (sum_w > 34'(ONE_Q30)) begin
      hav_w = ONE_Q30;
    end else begin
      hav_w = sum_w[30:0];
    end
  end

  logic [SQ_W-1:0] sq_n [2][0:SQRT_STEPS];
  logic [SQ_W-1:0] sq_r [2][0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (advance) begin
      m1_p1 <= sq1_w[62:30];
      m1_p2 <= sq2_w[62:30];
      m1_c1 <= sc_cos[2];
      m1_c2 <= sc_cos[3];
      m2_p1 <= m1_p1;
      m2_p3 <= pr3_w[62:30];
      m2_c2 <= m1_c2;
      m3_p1 <= m2_p1;
      m3_p4 <= pr4_w[62:30];
      sq_n[0][0] <= SQ_W'({hav_w, 30'b0});
      sq_n[1][0] <= SQ_W'({ONE_Q30 - hav_w, 30'b0});
      sq_r[0][0] <= '0;
      sq_r[1][0] <= '0;
    end
  end

  // bitwise square roots, one result bit per stage
  for (genvar j = 0; j < 2; j++) begin : g_sqrt
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_bit
      logic [SQ_W-1:0] bitv;
      logic [SQ_W-1:0] trial;

      assign bitv  = SQ_W'(1) << (60 - 2 * k);
      assign trial = sq_r[j][k] + bitv;

      always_ff @(posedge clk) begin
        if (advance) begin
          if (sq_n[j][k] >= trial) begin
            sq_n[j][k+1] <= sq_n[j][k] - trial;
            sq_r[j][k+1] <= (sq_r[j][k] >> 1) + bitv;
          end else begin
            sq_n[j][k+1] <= sq_n[j][k];
            sq_r[j][k+1] <= sq_r[j][k] >> 1;
          end
        end
      end
    end
  end

  // atan2(sqrt(a), sqrt(1 - a)) by vectoring
  logic signed [33:0] vx [0:CORDIC_STEPS];
  logic signed [33:0] vy [0:CORDIC_STEPS];
  logic signed [32:0] vz [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (advance) begin
      vx[0] <= 34'(sq_r[1][SQRT_STEPS][30:0]);
      vy[0] <= 34'(sq_r[0][SQRT_STEPS][30:0]);
      vz[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (advance) begin
        if (vy[i] > 34'sd0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + 33'(atan_bam(i));
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - 33'(atan_bam(i));
        end
      end
    end
  end

  // scale to 1/256 km
  logic [30:0]     zc_w;
  logic [61:0]     dprod_w;
  logic [61:0]     d1_prod;
  logic [23:0]     dq_w;
  dist_t           dist_w;
  dist_t           out_dist;
  logic            out_within;

  always_comb begin
    priority if (vz[CORDIC_STEPS] < 33'sd0) begin
      zc_w = '0;
    end else if (vz[CORDIC_STEPS] > 33'(ONE_Q30)) begin
      zc_w = ONE_Q30;
    end else begin
      zc_w = vz[CORDIC_STEPS][30:0];
    end
  end

  assign dprod_w = zc_w * DIST_SCALE;
  assign dq_w    = d1_prod[61:38];
  assign dist_w  = (dq_w > 24'(DIST_MAX)) ? DIST_MAX : dq_w[22:0];

  always_ff @(posedge clk) begin
    if (advance) begin
      d1_prod    <= dprod_w + (62'(1) << 37);
      out_dist   <= dist_w;
      out_within <= dist_w <= radius_limit;
    end
  end

  assign result.valid         = vld[LAT-1];
  assign result.result_tag    = tg[LAT-1];
  assign result.distance      = out_dist;
  assign result.within_radius = out_within;

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !point.ready)
    else $error("input taken while result stalled");

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.distance <= DIST_MAX))
    else $error("distance above saturation limit");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  a_pipe_delivers: assert property (@(posedge clk) disable iff (rst)
    (vld[LAT-2] && point.ready) |=> result.valid)
    else $error("request lost in last stage");
`endif

endmodule

@@ hdl/hrf_sincos.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_sincos
// Pipelined rotation CORDIC: binary angle in, Q30 sine and cosine out.
// Each stage advances only while en is high.
// ----------------------------------------------------------------------------
module hrf_sincos import hrf_pkg::*; #(
  parameter int STEPS = 20
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] ang,
  output trig_t       sin_q30,
  output trig_t       cos_q30
);

  logic signed [32:0] xs   [0:STEPS];
  logic signed [32:0] ys   [0:STEPS];
  logic signed [33:0] zs   [0:STEPS];
  logic               flip [0:STEPS];
  logic               quad_flip;
  logic [31:0]        ang_fold;

  assign quad_flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
  assign ang_fold  = quad_flip ? ang + 32'h8000_0000 : ang;

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]   <= CORDIC_GAIN;
      ys[0]   <= '0;
      zs[0]   <= 34'(signed'(ang_fold));
      flip[0] <= quad_flip;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (!zs[i][33]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - 34'(atan_bam(i));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + 34'(atan_bam(i));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q30 <= flip[STEPS] ? -ys[STEPS] : ys[STEPS];
      cos_q30 <= flip[STEPS] ? -xs[STEPS] : xs[STEPS];
    end
  end

endmodule
